@@ src/hbt_pkg.sv @@
// ============================================================================
// Hilditch thinning package
// Shared types, codes and the connectivity function for the thinning engine.
// ============================================================================
package hbt_pkg;

    // Item kinds carried in tuser
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [7:0] PIX_FG   = 8'd255;
    localparam logic [7:0] PIX_MARK = 8'd128;
    localparam logic [7:0] PIX_BG   = 8'd0;

    // Register indexes on the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Neighbour offsets: centre, then east and anticlockwise
    localparam logic signed [1:0] NB_DX [9] = '{2'sd0, 2'sd1, 2'sd1, 2'sd0, -2'sd1,
                                                 -2'sd1, -2'sd1, 2'sd0, 2'sd1};
    localparam logic signed [1:0] NB_DY [9] = '{2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1,
                                                 2'sd0, 2'sd1, 2'sd1, 2'sd1};

    // One neighbourhood value: foreground (1) or marked in this pass (-1)
    typedef struct packed {
        logic fg;
        logic mk;
    } t_nb;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDOUT,
        S_NB,
        S_EVAL,
        S_CLR_RD,
        S_CLR_WR,
        S_DONE
    } t_state;

    // True when the 8-connectivity number is one. occ[i] is neighbour i+1.
    function automatic logic conn_is_one(input logic [7:0] occ);
        logic [2:0] total;
        logic       a, b, c;
        total = 3'd0;
        for (int k = 0; k < 8; k += 2) begin
            a = ~occ[k];
            b = ~occ[k + 1];
            c = ~occ[(k + 2) % 8];
            total = total + {2'b00, a & ~(b & c)};
        end
        return total == 3'd1;
    endfunction

endpackage

@@ src/hbt_eval.sv @@
// ============================================================================
// Hilditch pixel test
// Decides from a 3x3 neighbourhood whether the centre pixel is marked.
// ============================================================================
module hbt_eval
    import hbt_pkg::*;
(
    input  t_nb [8:0] i_nb,
    output logic      o_mark
);

    logic [7:0] occ;
    logic [7:0] neg;
    logic [7:0] fgv;
    logic [7:0] ok_each;
    logic       border;
    logic       abs_two;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            occ[i] = i_nb[i + 1].fg | i_nb[i + 1].mk;
            neg[i] = i_nb[i + 1].mk;
            fgv[i] = i_nb[i + 1].fg;
        end
        border  = ~occ[0] | ~occ[2] | ~occ[4] | ~occ[6];
        abs_two = $countones(occ) >= 2;
        // Removing any one marked neighbour must keep the connectivity at one.
        for (int i = 0; i < 8; i++) begin
            ok_each[i] = ~neg[i] | conn_is_one(occ & ~(8'd1 << i));
        end
        o_mark = i_nb[0].fg & border & abs_two & (|fgv) & conn_is_one(occ) & (&ok_each);
    end

endmodule

@@ src/hilditch_binary_thinning.sv @@
// ============================================================================
// Hilditch binary thinning engine
// Image store with write, read and in-place 8-connected thinning items.
// ============================================================================
// Flow: a write beat is written to the store on acceptance; a read beat reads
// the store, then S_RDOUT registers the result once the output is free. A run
// makes per pass nine neighbour reads per active pixel from the single store
// read port, then a test, plus a read-then-write clearing sweep after each pass
// with marks. One write per cycle while idle; a read waits for the last result.
// Reset: synchronous, active low; clears control state, registers go to 256.
module hilditch_binary_thinning
    import hbt_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // col[7:0], row[15:8], pixel_in[23:16]
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // pixel_out[7:0], pass_count[23:8]
    output logic [0:0]  o_m_axis_tuser,   // is_pixel[0]
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // The store: one write port and one registered read port.
    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Configuration registers
    logic [8:0] r_cfg_w, r_cfg_h;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 9'd256;
            r_cfg_h <= 9'd256;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_cfg_w <= pwdata[8:0];
            end else begin
                r_cfg_h <= pwdata[8:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_WIDTH) ? {23'd0, r_cfg_w} : {23'd0, r_cfg_h};

    // Sequencer registers
    t_state        r_state, n_state;
    logic [XW-1:0] r_x, n_x, r_w, n_w;
    logic [YW-1:0] r_y, n_y, r_h, n_h;
    logic [3:0]    r_k, n_k;
    logic          r_pend_in, n_pend_in;
    logic          r_any, n_any;
    logic [15:0]   r_pass, n_pass;
    logic          r_in_inside, n_in_inside;
    t_nb [8:0]     r_nb, n_nb;
    logic          r_out_valid, n_out_valid;
    logic [23:0]   r_out_data, n_out_data;
    logic          r_out_pix, n_out_pix;

    logic [7:0]    in_col, in_row, in_pix;
    logic          in_inside, accept, out_free, mark;
    logic [AW-1:0] in_addr, ctr_addr, nb_addr;
    logic          nb_inside, last_x, last_y;
    logic [3:0]    kq;
    logic [XW-1:0] eff_w;
    logic [YW-1:0] eff_h;
    int            nx, ny;

    assign in_col    = i_s_axis_tdata[7:0];
    assign in_row    = i_s_axis_tdata[15:8];
    assign in_pix    = i_s_axis_tdata[23:16];
    assign in_inside = (int'(in_col) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);
    assign in_addr   = AW'(int'(in_row) * MAX_WIDTH + int'(in_col));
    assign ctr_addr  = AW'(int'(r_y) * MAX_WIDTH + int'(r_x));
    assign eff_w     = (int'(r_cfg_w) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(r_cfg_w);
    assign eff_h     = (int'(r_cfg_h) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(r_cfg_h);
    assign last_x    = XW'(r_x + 1'b1) == r_w;
    assign last_y    = YW'(r_y + 1'b1) == r_h;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;
    assign out_free        = ~r_out_valid | i_m_axis_tready;

    // Neighbour address for the fetch step; out-of-image neighbours read as 0.
    always_comb begin
        kq        = (r_k < 4'd9) ? r_k : 4'd0;
        nx        = int'(r_x) + int'(NB_DX[kq]);
        ny        = int'(r_y) + int'(NB_DY[kq]);
        nb_inside = (nx >= 0) && (nx < int'(r_w)) && (ny >= 0) && (ny < int'(r_h));
        nb_addr   = AW'(ny * MAX_WIDTH + nx);
    end

    hbt_eval u_eval (
        .i_nb   (r_nb),
        .o_mark (mark)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pass      <= 16'd0;
            r_any       <= 1'b0;
            r_k         <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pass      <= n_pass;
            r_any       <= n_any;
            r_k         <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_y         <= n_y;
        r_w         <= n_w;
        r_h         <= n_h;
        r_pend_in   <= n_pend_in;
        r_in_inside <= n_in_inside;
        r_nb        <= n_nb;
        r_out_data  <= n_out_data;
        r_out_pix   <= n_out_pix;
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_h         = r_h;
        n_k         = r_k;
        n_pend_in   = r_pend_in;
        n_any       = r_any;
        n_pass      = r_pass;
        n_in_inside = r_in_inside;
        n_nb        = r_nb;
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_pix   = r_out_pix;
        rd_en       = 1'b0;
        rd_addr     = in_addr;
        wr_en       = 1'b0;
        wr_addr     = ctr_addr;
        wr_data     = PIX_MARK;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_s_axis_tuser)
                        KIND_WRITE: begin
                            wr_en   = in_inside;
                            wr_addr = in_addr;
                            wr_data = in_pix;
                        end
                        KIND_READ: begin
                            rd_en       = in_inside;
                            n_in_inside = in_inside;
                            n_state     = S_RDOUT;
                        end
                        KIND_RUN: begin
                            n_w    = eff_w;
                            n_h    = eff_h;
                            n_x    = '0;
                            n_y    = '0;
                            n_k    = 4'd0;
                            n_any  = 1'b0;
                            // An empty image makes one pass with no marks.
                            if (eff_w == '0 || eff_h == '0) begin
                                n_pass  = 16'd1;
                                n_state = S_DONE;
                            end else begin
                                n_pass  = 16'd0;
                                n_state = S_NB;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDOUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = 1'b1;
                    n_out_data  = {16'd0, r_in_inside ? r_rdata : PIX_BG};
                    n_state     = S_IDLE;
                end
            end
            S_NB: begin
                // Read neighbour k this cycle; capture neighbour k-1 from the port.
                if (r_k < 4'd9) begin
                    rd_en     = nb_inside;
                    rd_addr   = nb_addr;
                    n_pend_in = nb_inside;
                end
                if (r_k != 4'd0) begin
                    n_nb[r_k - 4'd1].fg = r_pend_in & (r_rdata == PIX_FG);
                    n_nb[r_k - 4'd1].mk = r_pend_in & (r_rdata == PIX_MARK);
                end
                if (r_k == 4'd9) begin
                    n_state = S_EVAL;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            S_EVAL: begin
                wr_en = mark;
                n_any = r_any | mark;
                n_k   = 4'd0;
                if (!last_x) begin
                    n_x     = XW'(r_x + 1'b1);
                    n_state = S_NB;
                end else if (!last_y) begin
                    n_x     = '0;
                    n_y     = YW'(r_y + 1'b1);
                    n_state = S_NB;
                end else begin
                    n_x    = '0;
                    n_y    = '0;
                    n_pass = (r_pass != 16'hFFFF) ? r_pass + 16'd1 : r_pass;
                    n_state = (r_any | mark) ? S_CLR_RD : S_DONE;
                end
            end
            S_CLR_RD: begin
                rd_en   = 1'b1;
                rd_addr = ctr_addr;
                n_state = S_CLR_WR;
            end
            S_CLR_WR: begin
                wr_en   = (r_rdata == PIX_MARK);
                wr_data = PIX_BG;
                n_state = S_CLR_RD;
                if (!last_x) begin
                    n_x = XW'(r_x + 1'b1);
                end else if (!last_y) begin
                    n_x = '0;
                    n_y = YW'(r_y + 1'b1);
                end else begin
                    // Sweep finished: start the next pass.
                    n_x     = '0;
                    n_y     = '0;
                    n_any   = 1'b0;
                    n_k     = 4'd0;
                    n_state = S_NB;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = 1'b0;
                    n_out_data  = {r_pass, 8'd0};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_pix;

endmodule
